// ===== hw/rtl/stm_pkg.sv =====
// six thruster mixer: shared widths, mode codes and item types
// used by stm_div_pipe and six_thruster_mixer; no dependencies
package stm_pkg;

   // speed field width and the widths of the move-mode math
   localparam int SPEED_W = 16;
   localparam int MAG_W   = SPEED_W + 1;          // |speed|, up to 2^(W-1)
   localparam int AB_W    = SPEED_W + 2;          // signed a and b terms
   localparam int PROD_W  = SPEED_W + AB_W;       // signed sel * a
   localparam int NUM_W   = 2 * SPEED_W;          // |sel * a|
   localparam int DEN_W   = SPEED_W + 1;          // m = max(|a|, |b|)
   localparam int QUO_W   = SPEED_W + 1;          // quotient, at most 2^(W-1)

   typedef logic signed [SPEED_W-1:0] stm_speed_type;

   typedef enum logic [1:0] {
      MODE_MOVE  = 2'd0,
      MODE_STOP  = 2'd1,
      MODE_YAW   = 2'd2,
      MODE_PITCH = 2'd3
   } stm_mode_type;

   // input item
   typedef struct packed {
      stm_mode_type  mode;
      stm_speed_type move_speed;
      stm_speed_type rotate_speed;
      stm_speed_type vert_speed;
   } stm_req_type;

   // result item
   typedef struct packed {
      stm_speed_type engine_0_speed;
      stm_speed_type engine_1_speed;
      stm_speed_type engine_2_speed;
      stm_speed_type engine_3_speed;
      stm_speed_type engine_4_speed;
      stm_speed_type engine_5_speed;
   } stm_rsp_type;

   // side values that ride along with the division
   typedef struct packed {
      stm_mode_type  mode;
      stm_speed_type e0;
      stm_speed_type e1;
      stm_speed_type hz_pos;
      stm_speed_type hz_neg;
      logic          neg_a;
      logic          neg_b;
      logic          m_zero;
   } stm_tag_type;

endpackage

// ===== hw/rtl/stm_div_pipe.sv =====
// six thruster mixer: pipelined restoring divider, two numerators over one divisor
// one quotient bit per stage, valid and stall per stage; uses stm_pkg
module stm_div_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [stm_pkg::NUM_W-1:0] in_num_a,
   input  logic [stm_pkg::NUM_W-1:0] in_num_b,
   input  logic [stm_pkg::DEN_W-1:0] in_den,
   input  stm_pkg::stm_tag_type      in_tag,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [stm_pkg::QUO_W-1:0] out_quo_a,
   output logic [stm_pkg::QUO_W-1:0] out_quo_b,
   output stm_pkg::stm_tag_type      out_tag
);
   import stm_pkg::*;

   localparam int NSTG  = QUO_W;

   typedef struct packed {
      logic [DEN_W-1:0] rem_a;
      logic [DEN_W-1:0] rem_b;
      logic [QUO_W-1:0] low_a;
      logic [QUO_W-1:0] low_b;
      logic [QUO_W-1:0] quo_a;
      logic [QUO_W-1:0] quo_b;
      logic [DEN_W-1:0] den;
      stm_tag_type      tag;
   } div_stage_type;

   div_stage_type stg_ff [NSTG];
   div_stage_type stg_in [NSTG];
   div_stage_type src    [NSTG];
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic nb,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] t;
      logic [DEN_W:0] diff;
      logic           ge;
      t    = {rem, nb};
      ge   = (t >= {1'b0, den});
      diff = t - {1'b0, den};
      return ge ? {1'b1, diff[DEN_W-1:0]} : {1'b0, t[DEN_W-1:0]};
   endfunction

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   // entry: the high dividend bits are already below the divisor
   always_comb begin
      src[0].rem_a = DEN_W'(in_num_a[NUM_W-1:QUO_W]);
      src[0].rem_b = DEN_W'(in_num_b[NUM_W-1:QUO_W]);
      src[0].low_a = in_num_a[QUO_W-1:0];
      src[0].low_b = in_num_b[QUO_W-1:0];
      src[0].quo_a = '0;
      src[0].quo_b = '0;
      src[0].den   = in_den;
      src[0].tag   = in_tag;
   end

   for (genvar k = 1; k < NSTG; k++) begin : g_src
      assign src[k] = stg_ff[k-1];
   end

   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      localparam int BIT = NSTG - 1 - k;
      logic [DEN_W:0] sa;
      logic [DEN_W:0] sb;

      // one quotient bit for each numerator
      always_comb begin
         sa = div_step(src[k].rem_a, src[k].low_a[BIT], src[k].den);
         sb = div_step(src[k].rem_b, src[k].low_b[BIT], src[k].den);
         stg_in[k]       = src[k];
         stg_in[k].rem_a = sa[DEN_W-1:0];
         stg_in[k].rem_b = sb[DEN_W-1:0];
         stg_in[k].quo_a = {src[k].quo_a[QUO_W-2:0], sa[DEN_W]};
         stg_in[k].quo_b = {src[k].quo_b[QUO_W-2:0], sb[DEN_W]};
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   // valid bits travel with the stage data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_quo_a = stg_ff[NSTG-1].quo_a;
   assign out_quo_b = stg_ff[NSTG-1].quo_b;
   assign out_tag   = stg_ff[NSTG-1].tag;

endmodule

// ===== hw/rtl/six_thruster_mixer.sv =====
// six thruster mixer top level: command set in, six engine speeds out
// depends on stm_pkg and stm_div_pipe
//
//   channel  ports                          payload
//   input    req_valid / req_ready          req_data (mode, move, rotate, vert speeds)
//   output   rsp_valid / rsp_ready          rsp_data (engine 0..5 speeds)
//
// one item per cycle while rsp_ready does not stall the pipe; 22 stage registers lie
// between acceptance and rsp_valid: four math stages, 17 divider stages at one quotient
// bit each, one output register
// reset clears every stage valid bit; payload registers are not reset
// a stall on rsp_ready holds only the stages that are full, empty stages keep filling
module six_thruster_mixer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stm_pkg::stm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stm_pkg::stm_rsp_type rsp_data
);
   import stm_pkg::*;

   localparam stm_speed_type SPD_MAX = stm_speed_type'((1 << (SPEED_W - 1)) - 1);

   // signed result from a magnitude and a sign, clipped to the speed range
   function automatic stm_speed_type sat_mag(input logic [MAG_W-1:0] q, input logic neg);
      logic [MAG_W-1:0] nq;
      nq = -q;
      if (neg) begin
         return stm_speed_type'(nq[SPEED_W-1:0]);
      end else if (q > MAG_W'(SPD_MAX)) begin
         return SPD_MAX;
      end else begin
         return stm_speed_type'(q[SPEED_W-1:0]);
      end
   endfunction

   typedef struct packed {
      logic [MAG_W-1:0]        mag_mv;
      logic signed [MAG_W-1:0] srot;
      stm_speed_type           sel;
      stm_tag_type             tag;
   } s1_type;

   typedef struct packed {
      logic signed [AB_W-1:0] a;
      logic signed [AB_W-1:0] b;
      stm_speed_type          sel;
      stm_tag_type            tag;
   } s2_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] prod_a;
      logic signed [PROD_W-1:0] prod_b;
      logic [DEN_W-1:0]         m;
      stm_tag_type              tag;
   } s3_type;

   typedef struct packed {
      logic [NUM_W-1:0] num_a;
      logic [NUM_W-1:0] num_b;
      logic [DEN_W-1:0] den;
      stm_tag_type      tag;
   } s4_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   stm_rsp_type rsp_ff, rsp_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en_out;

   logic                    div_in_ready;
   logic                    div_out_valid;
   logic [QUO_W-1:0]        div_quo_a;
   logic [QUO_W-1:0]        div_quo_b;
   stm_tag_type             div_tag;

   // stage enables, back from the output register
   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en4       = !v4_ff || div_in_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   // stage 1: magnitudes, signed rotate, selection, side values
   always_comb begin
      logic signed [MAG_W-1:0] mv_x;
      logic signed [MAG_W-1:0] rot_x;
      logic [MAG_W-1:0]        mag_rot;
      mv_x         = MAG_W'(req_data.move_speed);
      rot_x        = MAG_W'(req_data.rotate_speed);
      s1_in.mag_mv = req_data.move_speed[SPEED_W-1] ? MAG_W'(-mv_x) : MAG_W'(mv_x);
      mag_rot      = req_data.rotate_speed[SPEED_W-1] ? MAG_W'(-rot_x) : MAG_W'(rot_x);
      s1_in.srot   = req_data.move_speed[SPEED_W-1] ? -rot_x : rot_x;
      s1_in.sel    = (s1_in.mag_mv > mag_rot) ? req_data.move_speed : req_data.rotate_speed;
      s1_in.tag.mode   = req_data.mode;
      s1_in.tag.hz_pos = sat_mag(mag_rot, 1'b0);
      s1_in.tag.hz_neg = sat_mag(mag_rot, 1'b1);
      s1_in.tag.neg_a  = 1'b0;
      s1_in.tag.neg_b  = 1'b0;
      s1_in.tag.m_zero = 1'b0;
      case (req_data.mode)
         MODE_MOVE, MODE_YAW: begin
            s1_in.tag.e0 = req_data.vert_speed;
            s1_in.tag.e1 = req_data.vert_speed;
         end
         MODE_PITCH: begin
            s1_in.tag.e0 = sat_mag(s1_in.mag_mv, 1'b1);
            s1_in.tag.e1 = sat_mag(s1_in.mag_mv, 1'b0);
         end
         default: begin
            s1_in.tag.e0 = '0;
            s1_in.tag.e1 = '0;
         end
      endcase
   end

   // stage 2: a = |move| + s*rot, b = s*rot - |move|
   always_comb begin
      logic signed [AB_W-1:0] mv_e;
      logic signed [AB_W-1:0] rot_e;
      mv_e      = AB_W'({1'b0, s1_ff.mag_mv});
      rot_e     = AB_W'(s1_ff.srot);
      s2_in.a   = mv_e + rot_e;
      s2_in.b   = rot_e - mv_e;
      s2_in.sel = s1_ff.sel;
      s2_in.tag = s1_ff.tag;
   end

   // stage 3: products and the divisor m = max(|a|, |b|)
   always_comb begin
      logic [AB_W-1:0] abs_a;
      logic [AB_W-1:0] abs_b;
      abs_a        = s2_ff.a[AB_W-1] ? AB_W'(-s2_ff.a) : AB_W'(s2_ff.a);
      abs_b        = s2_ff.b[AB_W-1] ? AB_W'(-s2_ff.b) : AB_W'(s2_ff.b);
      s3_in.m      = (abs_a > abs_b) ? abs_a[DEN_W-1:0] : abs_b[DEN_W-1:0];
      s3_in.prod_a = PROD_W'(s2_ff.sel) * PROD_W'(s2_ff.a);
      s3_in.prod_b = PROD_W'(s2_ff.sel) * PROD_W'(s2_ff.b);
      s3_in.tag    = s2_ff.tag;
   end

   // stage 4: product magnitudes and signs for the divider
   always_comb begin
      logic signed [PROD_W-1:0] abs_pa;
      logic signed [PROD_W-1:0] abs_pb;
      abs_pa           = s3_ff.prod_a[PROD_W-1] ? -s3_ff.prod_a : s3_ff.prod_a;
      abs_pb           = s3_ff.prod_b[PROD_W-1] ? -s3_ff.prod_b : s3_ff.prod_b;
      s4_in.num_a      = abs_pa[NUM_W-1:0];
      s4_in.num_b      = abs_pb[NUM_W-1:0];
      s4_in.den        = s3_ff.m;
      s4_in.tag        = s3_ff.tag;
      s4_in.tag.neg_a  = s3_ff.prod_a[PROD_W-1];
      s4_in.tag.neg_b  = s3_ff.prod_b[PROD_W-1];
      s4_in.tag.m_zero = (s3_ff.m == '0);
   end

   // math stage registers
   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   stm_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (div_in_ready),
      .in_num_a  (s4_ff.num_a),
      .in_num_b  (s4_ff.num_b),
      .in_den    (s4_ff.den),
      .in_tag    (s4_ff.tag),
      .out_valid (div_out_valid),
      .out_ready (en_out),
      .out_quo_a (div_quo_a),
      .out_quo_b (div_quo_b),
      .out_tag   (div_tag)
   );

   // output stage: signs, clipping and the mode select
   always_comb begin
      stm_speed_type e2, e3, e4, e5;
      e5 = sat_mag(div_quo_a, div_tag.neg_a);
      e2 = sat_mag(div_quo_a, !div_tag.neg_a);
      e4 = sat_mag(div_quo_b, div_tag.neg_b);
      e3 = sat_mag(div_quo_b, !div_tag.neg_b);
      rsp_in.engine_0_speed = div_tag.e0;
      rsp_in.engine_1_speed = div_tag.e1;
      case (div_tag.mode)
         MODE_MOVE: begin
            rsp_in.engine_2_speed = div_tag.m_zero ? '0 : e2;
            rsp_in.engine_3_speed = div_tag.m_zero ? '0 : e3;
            rsp_in.engine_4_speed = div_tag.m_zero ? '0 : e4;
            rsp_in.engine_5_speed = div_tag.m_zero ? '0 : e5;
         end
         MODE_YAW: begin
            rsp_in.engine_2_speed = div_tag.hz_neg;
            rsp_in.engine_3_speed = div_tag.hz_pos;
            rsp_in.engine_4_speed = div_tag.hz_pos;
            rsp_in.engine_5_speed = div_tag.hz_neg;
         end
         default: begin
            rsp_in.engine_2_speed = '0;
            rsp_in.engine_3_speed = '0;
            rsp_in.engine_4_speed = '0;
            rsp_in.engine_5_speed = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
